>>> hdl/lbpfm_pkg.sv
`timescale 1ns / 1ps
// Package for the buffer pool frame manager: field widths, codes and beat types.
// Used by the frame cell, the top level and the checker; depends on nothing.
package lbpfm_pkg;

  localparam int FRAMES_DEF = 16;
  localparam int PAGE_W     = 31;
  localparam int PIN_W      = 16;
  localparam int CNT_W      = 48;
  localparam int CFG_W      = 5;
  localparam int FIDX_W     = 4;
  localparam int APB_DW     = 32;
  localparam int APB_AW     = 3;

  localparam logic [PIN_W-1:0] PIN_MAX        = '1;
  localparam logic [CFG_W-1:0] CFG_FRAMES_RST = 5'd16;

  localparam logic REQ_FETCH = 1'b0;
  localparam logic REQ_UNPIN = 1'b1;

  // Register index taken from the word address bit.
  localparam logic REG_FRAMES_IN_USE = 1'b0;

  typedef enum logic [2:0] {
    STS_HIT      = 3'd0,
    STS_FILL     = 3'd1,
    STS_EVICT    = 3'd2,
    STS_NO_FRAME = 3'd3,
    STS_UNPINNED = 3'd4,
    STS_IGNORED  = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_HIT   = 3'd1,
    OP_UNPIN = 3'd2,
    OP_FILL  = 3'd3,
    OP_EVICT = 3'd4
  } op_t;

  typedef struct packed {
    logic              req_type;
    logic [PAGE_W-1:0] page_id;
  } in_item_t;

  typedef struct packed {
    status_t           status;
    logic [FIDX_W-1:0] frame_index;
    logic [PAGE_W-1:0] evicted_page;
    logic [CNT_W-1:0]  hit_total;
    logic [CNT_W-1:0]  miss_total;
  } out_item_t;

  typedef struct packed {
    op_t               op;
    logic [PAGE_W-1:0] page;
  } cell_cmd_t;

  typedef struct packed {
    logic valid;
    logic hit;
    logic elig;
    logic pins_nz;
    logic is_vic;
  } cell_flags_t;

endpackage

>>> hdl/lbpfm_cell.sv
`timescale 1ns / 1ps
// One frame of the pool: page id, pin count, recency rank and a fill bit.
// Depends on lbpfm_pkg; a frame fills only when its left neighbour already holds a page.
module lbpfm_cell
  import lbpfm_pkg::*;
#(
  parameter int RANK_W = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              prev_valid,
  input  cell_cmd_t         cmd,
  input  logic [RANK_W-1:0] old_rank,
  input  logic [RANK_W-1:0] vic_rank,
  output cell_flags_t       flags,
  output logic [RANK_W-1:0] rank,
  output logic [PAGE_W-1:0] page
);

  logic              valid_r, valid_nxt;
  logic [PIN_W-1:0]  pins_r, pins_nxt;
  logic [RANK_W-1:0] rank_r, rank_nxt;
  logic [PAGE_W-1:0] page_r, page_nxt;
  logic              hit, is_vic, target, touch;

  assign hit    = valid_r && (page_r == cmd.page);
  assign is_vic = valid_r && (rank_r == vic_rank);

  always_comb begin
    case (cmd.op)
      OP_HIT, OP_UNPIN: target = hit;
      OP_FILL:          target = prev_valid && !valid_r;
      OP_EVICT:         target = is_vic;
      default:          target = 1'b0;
    endcase
    touch = cmd.op inside {OP_HIT, OP_FILL, OP_EVICT};
  end

  always_comb begin
    valid_nxt = valid_r;
    pins_nxt  = pins_r;
    rank_nxt  = rank_r;
    page_nxt  = page_r;
    if (target) begin
      case (cmd.op)
        OP_HIT: begin
          if (pins_r != PIN_MAX) pins_nxt = pins_r + 1'b1;
        end
        OP_UNPIN: pins_nxt = pins_r - 1'b1;
        OP_FILL, OP_EVICT: begin
          pins_nxt  = {{(PIN_W-1){1'b0}}, 1'b1};
          page_nxt  = cmd.page;
          valid_nxt = 1'b1;
        end
        default: pins_nxt = pins_r;
      endcase
    end
    if (touch) begin
      if (target) begin
        rank_nxt = '0;
      end else if (valid_r && (rank_r < old_rank)) begin
        rank_nxt = rank_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      pins_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      pins_r  <= pins_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rank_r <= rank_nxt;
    page_r <= page_nxt;
  end

  assign flags = '{valid:   valid_r,
                   hit:     hit,
                   elig:    valid_r && (pins_r == '0),
                   pins_nz: pins_r != '0,
                   is_vic:  is_vic};
  assign rank  = rank_r;
  assign page  = page_r;

endmodule

>>> hdl/lru_buffer_pool_frame_manager.sv
`timescale 1ns / 1ps
// Frame manager of a page buffer pool with LRU eviction and pin counts.
// A request passes the match, pick and update states; its result beat is registered
// when the update applies. No new request is taken until the update has applied, and
// the update waits while the previous result beat is held by out_stall.
// Reset: synchronous, active low; pin counts, fill state and counters clear at once.
// Depends on lbpfm_pkg and lbpfm_cell.
module lru_buffer_pool_frame_manager
  import lbpfm_pkg::*;
#(
  parameter int FRAMES = FRAMES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [APB_AW-1:0] cfg_paddr,
  input  logic [APB_DW-1:0] cfg_pwdata,
  output logic [APB_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  localparam int IDX_W  = $clog2(FRAMES);
  localparam int FILL_W = $clog2(FRAMES + 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_MATCH = 4'b0010,
    S_PICK  = 4'b0100,
    S_APPLY = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  in_item_t            req_r;
  logic [CFG_W-1:0]    cfg_frames_r;
  logic [FILL_W-1:0]   filled_r;
  logic [CNT_W-1:0]    hit_cnt_r, miss_cnt_r, hit_cnt_nxt, miss_cnt_nxt;

  cell_flags_t         flags [FRAMES];
  logic [IDX_W-1:0]    ranks [FRAMES];
  logic [PAGE_W-1:0]   pages [FRAMES];
  cell_cmd_t           cmd;

  // Match stage results.
  logic                hit_any, hit_any_r;
  logic [IDX_W-1:0]    hit_idx, hit_idx_r;
  logic [IDX_W-1:0]    hit_rank, hit_rank_r;
  logic                hit_pins_nz, hit_pins_nz_r;
  logic [FRAMES-1:0]   elig_vec, elig_vec_r;

  // Pick stage results.
  logic                vic_any;
  logic [IDX_W-1:0]    vic_rank_p, vic_rank_r;
  op_t                 op_p, op_r;
  status_t             status_p, status_r;
  logic [IDX_W-1:0]    fidx_p, fidx_r;
  logic [IDX_W-1:0]    old_rank_p, old_rank_r;
  logic                miss_p, miss_r;
  logic                can_fill;

  // Update stage.
  logic                apply_go;
  logic [IDX_W-1:0]    vic_idx;
  logic [PAGE_W-1:0]   vic_page;
  logic [IDX_W+FIDX_W-1:0] fidx_ext;
  logic                out_valid_r;
  out_item_t           out_data_r;
  logic                cfg_wr;

  // Configuration port.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == REG_FRAMES_IN_USE) ?
                      {{(APB_DW-CFG_W){1'b0}}, cfg_frames_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_frames_r <= CFG_FRAMES_RST;
    end else if (cfg_wr && (cfg_paddr[2] == REG_FRAMES_IN_USE)) begin
      cfg_frames_r <= cfg_pwdata[CFG_W-1:0];
    end
  end

  // Row of frame cells.
  assign apply_go = (state_r == S_APPLY) && !(out_valid_r && out_stall);
  assign cmd      = '{op: apply_go ? op_r : OP_NONE, page: req_r.page_id};

  for (genvar g = 0; g < FRAMES; g++) begin : g_cell
    lbpfm_cell #(
      .RANK_W (IDX_W)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .prev_valid ((g == 0) ? 1'b1 : flags[(g == 0) ? 0 : g-1].valid),
      .cmd        (cmd),
      .old_rank   (old_rank_r),
      .vic_rank   (vic_rank_r),
      .flags      (flags[g]),
      .rank       (ranks[g]),
      .page       (pages[g])
    );
  end

  // Match stage: gather the hit frame and the unpinned frames by rank.
  always_comb begin
    hit_any     = 1'b0;
    hit_idx     = '0;
    hit_rank    = '0;
    hit_pins_nz = 1'b0;
    elig_vec    = '0;
    for (int g = 0; g < FRAMES; g++) begin
      if (flags[g].hit) begin
        hit_any     = 1'b1;
        hit_idx     = IDX_W'(g);
        hit_rank    = ranks[g];
        hit_pins_nz = flags[g].pins_nz;
      end
    end
    for (int r = 0; r < FRAMES; r++) begin
      for (int g = 0; g < FRAMES; g++) begin
        if (flags[g].elig && (ranks[g] == IDX_W'(r))) elig_vec[r] = 1'b1;
      end
    end
  end

  // Pick stage: oldest unpinned frame and the decision.
  always_comb begin
    vic_any    = 1'b0;
    vic_rank_p = '0;
    for (int r = 0; r < FRAMES; r++) begin
      if (elig_vec_r[r]) begin
        vic_any    = 1'b1;
        vic_rank_p = IDX_W'(r);
      end
    end
    can_fill   = (32'(filled_r) < 32'(cfg_frames_r)) && (32'(filled_r) < FRAMES);
    op_p       = OP_NONE;
    status_p   = STS_IGNORED;
    fidx_p     = '0;
    old_rank_p = '0;
    miss_p     = 1'b0;
    if (req_r.req_type == REQ_UNPIN) begin
      if (hit_any_r && hit_pins_nz_r) begin
        op_p     = OP_UNPIN;
        status_p = STS_UNPINNED;
        fidx_p   = hit_idx_r;
      end
    end else if (hit_any_r) begin
      op_p       = OP_HIT;
      status_p   = STS_HIT;
      fidx_p     = hit_idx_r;
      old_rank_p = hit_rank_r;
    end else begin
      miss_p = 1'b1;
      if (can_fill) begin
        op_p       = OP_FILL;
        status_p   = STS_FILL;
        fidx_p     = filled_r[IDX_W-1:0];
        old_rank_p = filled_r[IDX_W-1:0];
      end else if (vic_any) begin
        op_p       = OP_EVICT;
        status_p   = STS_EVICT;
        old_rank_p = vic_rank_p;
      end else begin
        status_p = STS_NO_FRAME;
      end
    end
  end

  // Update stage: locate the victim frame and its old page.
  always_comb begin
    vic_idx  = '0;
    vic_page = '0;
    for (int g = 0; g < FRAMES; g++) begin
      if (flags[g].is_vic) begin
        vic_idx  = IDX_W'(g);
        vic_page = pages[g];
      end
    end
    fidx_ext     = {{FIDX_W{1'b0}}, (op_r == OP_EVICT) ? vic_idx : fidx_r};
    hit_cnt_nxt  = hit_cnt_r + ((op_r == OP_HIT) ? CNT_W'(1) : CNT_W'(0));
    miss_cnt_nxt = miss_cnt_r + (miss_r ? CNT_W'(1) : CNT_W'(0));
  end

  always_comb begin
    case (state_r)
      S_IDLE:  state_nxt = in_valid ? S_MATCH : S_IDLE;
      S_MATCH: state_nxt = S_PICK;
      S_PICK:  state_nxt = S_APPLY;
      S_APPLY: state_nxt = apply_go ? S_IDLE : S_APPLY;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      filled_r    <= '0;
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (apply_go) begin
        hit_cnt_r  <= hit_cnt_nxt;
        miss_cnt_r <= miss_cnt_nxt;
        if (op_r == OP_FILL) filled_r <= filled_r + 1'b1;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_IDLE) && in_valid) req_r <= in_data;
    if (state_r == S_MATCH) begin
      hit_any_r     <= hit_any;
      hit_idx_r     <= hit_idx;
      hit_rank_r    <= hit_rank;
      hit_pins_nz_r <= hit_pins_nz;
      elig_vec_r    <= elig_vec;
    end
    if (state_r == S_PICK) begin
      op_r       <= op_p;
      status_r   <= status_p;
      fidx_r     <= fidx_p;
      old_rank_r <= old_rank_p;
      vic_rank_r <= vic_rank_p;
      miss_r     <= miss_p;
    end
    if (apply_go) begin
      out_data_r <= '{status:       status_r,
                      frame_index:  fidx_ext[FIDX_W-1:0],
                      evicted_page: (op_r == OP_EVICT) ? vic_page : '0,
                      hit_total:    hit_cnt_nxt,
                      miss_total:   miss_cnt_nxt};
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> hdl/lbpfm_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the frame manager, bound to the top level below.
// Depends on lbpfm_pkg and lru_buffer_pool_frame_manager.
module lbpfm_checker
  import lbpfm_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request beat accepted while another request is in progress");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == STS_HIT || out_data.status == STS_FILL ||
                   out_data.status == STS_EVICT || out_data.status == STS_NO_FRAME ||
                   out_data.status == STS_UNPINNED || out_data.status == STS_IGNORED))
    else $error("result beat carries an unknown status");

  a_no_frame_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status == STS_NO_FRAME || out_data.status == STS_IGNORED))
      |-> (out_data.frame_index == '0))
    else $error("frame index set on a result without a frame");

  a_evicted_page: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status != STS_EVICT)) |-> (out_data.evicted_page == '0))
    else $error("evicted page reported without an eviction");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result beat changed");

endmodule

bind lru_buffer_pool_frame_manager lbpfm_checker u_lbpfm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
